@@ rtl/core/adfk_pkg.sv @@
package adfk_pkg;

   localparam int KEY_W = 64;
   localparam int VAL_W = 64;

   typedef enum logic [1:0] {
      ACT_ELEM  = 2'd0,
      ACT_EMPTY = 2'd1,
      ACT_NULL  = 2'd2,
      ACT_RSVD  = 2'd3
   } action_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_DECIDE = 1'b1
   } state_type;

   // controls broadcast along the row of cells
   typedef struct packed {
      logic             capture;
      logic             shift;
      logic             float_keys;
      logic [KEY_W-1:0] probe_key;
   } cell_ctrl_type;

   typedef struct packed {
      action_type       action;
      logic [KEY_W-1:0] key;
      logic             key_is_null;
      logic [VAL_W-1:0] value;
      logic             value_is_null;
      logic             last_in_row;
   } item_type;

   function automatic logic key_is_nan(input logic [KEY_W-1:0] k);
      return (k[62:52] == 11'h7FF) && (k[51:0] != 52'd0);
   endfunction

   function automatic logic keys_equal(input logic [KEY_W-1:0] a,
                                       input logic [KEY_W-1:0] b,
                                       input logic             fk);
      logic eq;
      eq = (a == b);
      if (fk) begin
         if (key_is_nan(a) || key_is_nan(b)) begin
            eq = 1'b0;
         end else if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
            eq = 1'b1;
         end
      end
      return eq;
   endfunction

endpackage

@@ rtl/core/array_dedup_first_by_key.sv @@
// Keep-first deduplication of key/value pairs grouped into rows. For each
// accepted transfer, at the accept edge every cell of the key row compares
// its stored key with the incoming key and registers a hit flag; in the
// decide state the hit flags are OR-ed and, once the output register is free,
// the result is written to it and a new key is pushed into the head of the
// row, every stored key moving one cell on. The next transfer is taken after
// that write, so a stalled result costs the cycles it is held. Up to MAX_KEYS
// distinct keys per row are remembered; further new keys pass unchecked and
// raise overflow. The store empties at every row end with no clearing pass.
module array_dedup_first_by_key
   import adfk_pkg::*;
#(
   parameter int MAX_KEYS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_float_keys,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_action,
   input  logic [KEY_W-1:0] req_key,
   input  logic             req_key_is_null,
   input  logic [VAL_W-1:0] req_value,
   input  logic             req_value_is_null,
   input  logic             req_last_in_row,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_keep,
   output logic [VAL_W-1:0] rsp_out_value,
   output logic             rsp_out_value_null,
   output logic             rsp_row_end,
   output logic             rsp_row_null,
   output logic             rsp_overflow
);

   localparam int CNT_W = $clog2(MAX_KEYS + 1);

   state_type        state_ff, state_in;
   item_type         item_ff, item_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             float_ff, float_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             keep_ff, keep_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic             vnull_ff, vnull_in;
   logic             row_end_ff, row_end_in;
   logic             row_null_ff, row_null_in;
   logic             rovf_ff, rovf_in;

   logic                accept;
   logic                fire;
   logic                decide;
   cell_ctrl_type       ctrl;
   logic [MAX_KEYS-1:0] active;
   logic [MAX_KEYS-1:0] hit_vec;
   logic [KEY_W-1:0]    chain [MAX_KEYS+1];
   logic                found;
   logic                nan_key;
   logic                insert;
   logic                ovf_set;
   logic                produce;
   logic                keep_c;
   logic                row_end_c;
   logic                row_null_c;
   logic                full;

   assign accept = req_valid && !req_stall;
   assign fire   = decide && (!rsp_valid_ff || !rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_DECIDE;
         ST_DECIDE: if (fire) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      decide    = 1'b0;
      case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_DECIDE: decide = 1'b1;
         default:   req_stall = 1'b1;
      endcase
   end

   assign csr_ready = 1'b1;

   always_comb begin
      item_in = item_ff;
      if (accept) begin
         item_in.action        = action_type'(req_action);
         item_in.key           = req_key;
         item_in.key_is_null   = req_key_is_null;
         item_in.value         = req_value;
         item_in.value_is_null = req_value_is_null;
         item_in.last_in_row   = req_last_in_row;
      end
   end

   assign float_in = (csr_valid && csr_ready) ? csr_float_keys : float_ff;

   // row of key cells
   assign full    = (count_ff == CNT_W'(MAX_KEYS));
   assign found   = |hit_vec;
   assign nan_key = float_ff && key_is_nan(item_ff.key);

   always_comb begin
      produce    = 1'b1;
      keep_c     = 1'b0;
      row_end_c  = 1'b0;
      row_null_c = 1'b0;
      insert     = 1'b0;
      ovf_set    = 1'b0;
      case (item_ff.action)
         ACT_ELEM: begin
            row_end_c = item_ff.last_in_row;
            if (!item_ff.key_is_null) begin
               keep_c = !found;
               if (!nan_key && !found) begin
                  insert  = !full;
                  ovf_set = full;
               end
            end
         end
         ACT_EMPTY: row_end_c = 1'b1;
         ACT_NULL: begin
            row_end_c  = 1'b1;
            row_null_c = 1'b1;
         end
         default: produce = 1'b0;
      endcase
   end

   always_comb begin
      ctrl.capture    = accept;
      ctrl.shift      = fire && insert;
      ctrl.float_keys = float_ff;
      ctrl.probe_key  = req_key;
   end

   assign chain[0] = item_ff.key;

   for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
      assign active[g] = (CNT_W'(g) < count_ff);
      adfk_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .active   (active[g]),
         .key_prev (chain[g]),
         .key_out  (chain[g+1]),
         .hit      (hit_vec[g])
      );
   end

   // row bookkeeping and result register
   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      keep_in      = keep_ff;
      value_in     = value_ff;
      vnull_in     = vnull_ff;
      row_end_in   = row_end_ff;
      row_null_in  = row_null_ff;
      rovf_in      = rovf_ff;
      if (fire && produce) begin
         rsp_valid_in = 1'b1;
         keep_in      = keep_c;
         value_in     = (keep_c && !item_ff.value_is_null) ? item_ff.value : '0;
         vnull_in     = keep_c && item_ff.value_is_null;
         row_end_in   = row_end_c;
         row_null_in  = row_null_c;
         rovf_in      = ovf_ff || ovf_set;
         if (row_end_c) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            if (insert) count_in = CNT_W'(count_ff + 1'b1);
            if (ovf_set) ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         float_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         float_ff     <= float_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      keep_ff     <= keep_in;
      value_ff    <= value_in;
      vnull_ff    <= vnull_in;
      row_end_ff  <= row_end_in;
      row_null_ff <= row_null_in;
      rovf_ff     <= rovf_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_keep           = keep_ff;
   assign rsp_out_value      = value_ff;
   assign rsp_out_value_null = vnull_ff;
   assign rsp_row_end        = row_end_ff;
   assign rsp_row_null       = row_null_ff;
   assign rsp_overflow       = rovf_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_KEYS))
      else $error("key count beyond store depth");

   a_accept_decide: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_DECIDE)
      else $error("accepted transfer not followed by decide cycle");

   a_row_close: assert property (@(posedge clock) disable iff (reset)
      fire && produce && row_end_c |=> count_ff == '0 && !ovf_ff)
      else $error("row end did not clear the key store");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      fire && ovf_set |-> full && !insert)
      else $error("overflow raised while store has room");
`endif

endmodule

@@ rtl/core/adfk_cell.sv @@
module adfk_cell
   import adfk_pkg::*;
(
   input  logic             clock,
   input  cell_ctrl_type    ctrl,
   input  logic             active,
   input  logic [KEY_W-1:0] key_prev,
   output logic [KEY_W-1:0] key_out,
   output logic             hit
);

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   logic             hit_ff;
   logic             hit_in;

   always_comb begin
      key_in = ctrl.shift ? key_prev : key_ff;
      hit_in = ctrl.capture ? (active && keys_equal(key_ff, ctrl.probe_key, ctrl.float_keys))
                            : hit_ff;
   end

   // stored key moves one cell down the row on every insert
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      hit_ff <= hit_in;
   end

   assign key_out = key_ff;
   assign hit     = hit_ff;

endmodule
